// ===== hw/rtl/mfr_pkg.sv =====
// Shared constants and codes for the MUSCL face reconstruction block.
`default_nettype none
package mfr_pkg;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int IN_WIDTH        = 32;
   localparam int DIST_WIDTH      = 31;
   localparam int OUT_WIDTH       = 32;
   localparam int KAPPA_WIDTH     = 18;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 18;
   localparam int MUL_LATENCY     = 3;
   localparam int DIV_STEP        = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LIMITER_MODE = 2'd0,
      CSR_KAPPA        = 2'd1
   } csr_index_type;
endpackage
`default_nettype wire

// ===== hw/rtl/mfr_delay.sv =====
// Enabled shift-register delay line for side data traveling beside the arithmetic units.
`default_nettype none
module mfr_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] d,
   output logic      [WIDTH-1:0] q
);
   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) pipe_ff[i] <= '0;
      end else if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign q = pipe_ff[DEPTH-1];
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_mul.sv =====
// Three-stage saturating fixed-point multiplier, truncating toward zero.
`default_nettype none
module mfr_mul #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic      [W-1:0] q,
   output logic              sat
);
   localparam logic [2*W-1:0] LIM_POS = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [2*W-1:0] LIM_NEG = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]   MAXV    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]   MINV    = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]   ua_ff, ub_ff, ua_in, ub_in;
   logic           neg1_ff, neg2_ff;
   logic [2*W-1:0] p_ff, p_in, sh;
   logic [W-1:0]   q_ff, q_in;
   logic           sat_ff, sat_in;

   always_comb begin
      ua_in = a[W-1] ? (~a + 1'b1) : a;
      ub_in = b[W-1] ? (~b + 1'b1) : b;
      p_in  = {{W{1'b0}}, ua_ff} * {{W{1'b0}}, ub_ff};
      sh    = p_ff >> F;
      if (sh > (neg2_ff ? LIM_NEG : LIM_POS)) begin
         q_in   = neg2_ff ? MINV : MAXV;
         sat_in = 1'b1;
      end else begin
         q_in   = neg2_ff ? (~sh[W-1:0] + 1'b1) : sh[W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg1_ff <= a[W-1] ^ b[W-1];
         p_ff    <= p_in;
         neg2_ff <= neg1_ff;
         q_ff    <= q_in;
         sat_ff  <= sat_in;
      end
   end

   assign q   = q_ff;
   assign sat = sat_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_div.sv =====
// Pipelined restoring divider, (a << F) / b, two quotient bits per stage, saturating.
`default_nettype none
module mfr_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic      [W-1:0] q,
   output logic              sat
);
   import mfr_pkg::*;

   localparam int NQ = W + F;
   localparam int S  = (NQ + DIV_STEP - 1) / DIV_STEP;
   localparam logic [NQ-1:0] LIM_POS = {{(F+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NQ-1:0] LIM_NEG = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};

   logic [W:0]    rem_ff [S+1];
   logic [NQ-1:0] dvd_ff [S+1];
   logic [NQ-1:0] quo_ff [S+1];
   logic [W-1:0]  ub_ff  [S+1];
   logic          neg_ff [S+1];
   logic          an_ff  [S+1];
   logic          bz_ff  [S+1];

   logic [W-1:0]  ua_in, ub_in;
   logic [W-1:0]  q_ff, q_in;
   logic          sat_ff, sat_in;

   assign ua_in = a[W-1] ? (~a + 1'b1) : a;
   assign ub_in = b[W-1] ? (~b + 1'b1) : b;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dvd_ff[0] <= {ua_in, {F{1'b0}}};
         quo_ff[0] <= '0;
         ub_ff[0]  <= ub_in;
         neg_ff[0] <= a[W-1] ^ b[W-1];
         an_ff[0]  <= a[W-1];
         bz_ff[0]  <= (b == '0);
      end
   end

   for (genvar s = 0; s < S; s++) begin : g_stage
      logic [W:0]    rem_in, trial;
      logic [NQ-1:0] dvd_in, quo_in;

      always_comb begin
         rem_in = rem_ff[s];
         dvd_in = dvd_ff[s];
         quo_in = quo_ff[s];
         trial  = '0;
         for (int j = 0; j < DIV_STEP; j++) begin
            if (s * DIV_STEP + j < NQ) begin
               trial  = {rem_in[W-1:0], dvd_in[NQ-1]};
               dvd_in = dvd_in << 1;
               if (trial >= {1'b0, ub_ff[s]}) begin
                  rem_in = trial - {1'b0, ub_ff[s]};
                  quo_in = {quo_in[NQ-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_in[NQ-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            dvd_ff[s+1] <= dvd_in;
            quo_ff[s+1] <= quo_in;
            ub_ff[s+1]  <= ub_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            an_ff[s+1]  <= an_ff[s];
            bz_ff[s+1]  <= bz_ff[s];
         end
      end
   end

   always_comb begin
      if (bz_ff[S]) begin
         q_in   = an_ff[S] ? MINV : MAXV;
         sat_in = 1'b1;
      end else if (quo_ff[S] > (neg_ff[S] ? LIM_NEG : LIM_POS)) begin
         q_in   = neg_ff[S] ? MINV : MAXV;
         sat_in = 1'b1;
      end else begin
         q_in   = neg_ff[S] ? (~quo_ff[S][W-1:0] + 1'b1) : quo_ff[S][W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign q   = q_ff;
   assign sat = sat_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/muscl_face_reconstruction.sv =====
// MUSCL kappa face reconstruction with optional van Albada limiting, deep pipeline.
// Throughput: one beat per cycle while the output is not stalled; the pipeline depth
// is set by four chained divider pipelines.
// Reset: synchronous; clears all valid bits, limiter_mode to van Albada, kappa to zero.
`default_nettype none
module muscl_face_reconstruction #(
   parameter int VALUE_WIDTH = mfr_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = mfr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [mfr_pkg::IN_WIDTH-1:0]       req_far_upwind,
   input  wire logic [mfr_pkg::IN_WIDTH-1:0]       req_near_upwind,
   input  wire logic [mfr_pkg::IN_WIDTH-1:0]       req_downwind,
   input  wire logic [mfr_pkg::DIST_WIDTH-1:0]     req_upwind_distance,
   input  wire logic [mfr_pkg::DIST_WIDTH-1:0]     req_central_distance,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [mfr_pkg::OUT_WIDTH-1:0]      rsp_face_value,
   output logic                                    rsp_saturated,
   input  wire logic                               csr_wr_en,
   input  wire logic [mfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mfr_pkg::CSR_DATA_WIDTH-1:0]  csr_wr_data
);
   import mfr_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int XW = (W > IN_WIDTH) ? W : IN_WIDTH;
   localparam int LD = (W + F + DIV_STEP - 1) / DIV_STEP + 2;
   localparam int LM = MUL_LATENCY;
   localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};
   localparam logic         ONE_SAT = (F >= W - 1);
   localparam logic [W-1:0] ONE_V = ONE_SAT ? MAXV : (W'(1) << F);
   localparam logic [W-1:0] ONE_LSB = W'(1);

   function automatic logic [W:0] sat_fix(input logic [W:0] x);
      if (x[W] != x[W-1]) sat_fix = {1'b1, x[W] ? MINV : MAXV};
      else sat_fix = {1'b0, x[W-1:0]};
   endfunction

   function automatic logic [W:0] add_s(input logic [W-1:0] a, input logic [W-1:0] b);
      add_s = sat_fix({a[W-1], a} + {b[W-1], b});
   endfunction

   function automatic logic [W:0] sub_s(input logic [W-1:0] a, input logic [W-1:0] b);
      sub_s = sat_fix({a[W-1], a} - {b[W-1], b});
   endfunction

   function automatic logic [W:0] clamp_in(input logic signed [IN_WIDTH-1:0] x);
      logic signed [XW-1:0] xe;
      xe = XW'(x);
      if (xe > XW'(signed'(MAXV))) clamp_in = {1'b1, MAXV};
      else if (xe < XW'(signed'(MINV))) clamp_in = {1'b1, MINV};
      else clamp_in = {1'b0, xe[W-1:0]};
   endfunction

   // configuration
   logic                   mode_ff;
   logic [KAPPA_WIDTH-1:0] kappa_ff;
   logic [W:0]             k_c, omk_c, opk_c;
   logic                   cfg_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         kappa_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LIMITER_MODE: mode_ff  <= csr_wr_data[0];
            CSR_KAPPA:        kappa_ff <= csr_wr_data[KAPPA_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      k_c     = clamp_in(IN_WIDTH'(signed'(kappa_ff)));
      omk_c   = sub_s(ONE_V, k_c[W-1:0]);
      opk_c   = add_s(ONE_V, k_c[W-1:0]);
      cfg_sat = k_c[W] | omk_c[W] | opk_c[W] | ONE_SAT;
   end

   // handshake: skid register in front of a pipeline that freezes on output stall
   logic adv, in_acc;
   logic skid_full_ff, skid_full_in;
   logic [IN_WIDTH-1:0]   sk_far_ff, sk_near_ff, sk_down_ff;
   logic [DIST_WIDTH-1:0] sk_ud_ff, sk_cd_ff;
   logic                  rsp_valid_ff;

   assign adv    = ~(rsp_valid_ff & rsp_stall);
   assign in_acc = req_valid & ~skid_full_ff;

   always_comb begin
      skid_full_in = skid_full_ff;
      if (adv) skid_full_in = 1'b0;
      else if (in_acc) skid_full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) skid_full_ff <= 1'b0;
      else skid_full_ff <= skid_full_in;
   end

   always_ff @(posedge clock) begin
      if (!adv && in_acc) begin
         sk_far_ff  <= req_far_upwind;
         sk_near_ff <= req_near_upwind;
         sk_down_ff <= req_downwind;
         sk_ud_ff   <= req_upwind_distance;
         sk_cd_ff   <= req_central_distance;
      end
   end

   assign req_stall = skid_full_ff;

   // entry stage
   logic                  e_v_ff, e_v_in;
   logic [IN_WIDTH-1:0]   e_far_ff, e_near_ff, e_down_ff, e_far_in, e_near_in, e_down_in;
   logic [DIST_WIDTH-1:0] e_ud_ff, e_cd_ff, e_ud_in, e_cd_in;

   always_comb begin
      e_v_in    = skid_full_ff | in_acc;
      e_far_in  = skid_full_ff ? sk_far_ff  : req_far_upwind;
      e_near_in = skid_full_ff ? sk_near_ff : req_near_upwind;
      e_down_in = skid_full_ff ? sk_down_ff : req_downwind;
      e_ud_in   = skid_full_ff ? sk_ud_ff   : req_upwind_distance;
      e_cd_in   = skid_full_ff ? sk_cd_ff   : req_central_distance;
   end

   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= e_v_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_far_ff  <= e_far_in;
         e_near_ff <= e_near_in;
         e_down_ff <= e_down_in;
         e_ud_ff   <= e_ud_in;
         e_cd_ff   <= e_cd_in;
      end
   end

   // t1: clamp into the number format
   logic [W:0]   cf, cn, cdn, cud, ccd;
   logic         c_v_ff, c_sat_ff, c_sat_in;
   logic [W-1:0] c_far_ff, c_near_ff, c_down_ff, c_ud_ff, c_cd_ff;

   always_comb begin
      cf       = clamp_in(signed'(e_far_ff));
      cn       = clamp_in(signed'(e_near_ff));
      cdn      = clamp_in(signed'(e_down_ff));
      cud      = clamp_in(signed'({1'b0, e_ud_ff}));
      ccd      = clamp_in(signed'({1'b0, e_cd_ff}));
      c_sat_in = cf[W] | cn[W] | cdn[W] | cud[W] | ccd[W];
   end

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= e_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_sat_ff  <= c_sat_in;
         c_far_ff  <= cf[W-1:0];
         c_near_ff <= cn[W-1:0];
         c_down_ff <= cdn[W-1:0];
         c_ud_ff   <= cud[W-1:0];
         c_cd_ff   <= ccd[W-1:0];
      end
   end

   // t2: differences
   logic [W:0]   dn_c, nf_c;
   logic         d_v_ff, d_sat_ff;
   logic [W-1:0] d_dn_ff, d_nf_ff, d_near_ff, d_ud_ff, d_cd_ff;

   assign dn_c = sub_s(c_down_ff, c_near_ff);
   assign nf_c = sub_s(c_near_ff, c_far_ff);

   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_sat_ff  <= c_sat_ff | dn_c[W] | nf_c[W];
         d_dn_ff   <= dn_c[W-1:0];
         d_nf_ff   <= nf_c[W-1:0];
         d_near_ff <= c_near_ff;
         d_ud_ff   <= c_ud_ff;
         d_cd_ff   <= c_cd_ff;
      end
   end

   // t3: epsilon of one LSB
   logic [W:0]   nd_c, dd_c;
   logic         p_v_ff, p_sat_ff;
   logic [W-1:0] p_nd_ff, p_dd_ff, p_nf_ff, p_near_ff, p_ud_ff, p_cd_ff;

   assign nd_c = add_s(d_dn_ff, ONE_LSB);
   assign dd_c = add_s(d_nf_ff, ONE_LSB);

   always_ff @(posedge clock) begin
      if (reset) p_v_ff <= 1'b0;
      else if (adv) p_v_ff <= d_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_sat_ff  <= d_sat_ff | nd_c[W] | dd_c[W];
         p_nd_ff   <= nd_c[W-1:0];
         p_dd_ff   <= dd_c[W-1:0];
         p_nf_ff   <= d_nf_ff;
         p_near_ff <= d_near_ff;
         p_ud_ff   <= d_ud_ff;
         p_cd_ff   <= d_cd_ff;
      end
   end

   // scaled differences
   logic [W-1:0] num_q, den_q;
   logic         num_sat, den_sat;
   logic [2*W+1:0] s4;

   mfr_div #(.W(W), .F(F)) u_div_num (
      .clock(clock), .en(adv), .a(p_nd_ff), .b(p_cd_ff), .q(num_q), .sat(num_sat));
   mfr_div #(.W(W), .F(F)) u_div_den (
      .clock(clock), .en(adv), .a(p_dd_ff), .b(p_ud_ff), .q(den_q), .sat(den_sat));
   mfr_delay #(.WIDTH(2*W+2), .DEPTH(LD)) u_dly4 (
      .clock(clock), .reset(reset), .en(adv),
      .d({p_v_ff, p_sat_ff, p_near_ff, p_nf_ff}), .q(s4));

   // ratio r
   logic [W-1:0]   r_q;
   logic           r_sat;
   logic [2*W+1:0] s5;

   mfr_div #(.W(W), .F(F)) u_div_r (
      .clock(clock), .en(adv), .a(num_q), .b(den_q), .q(r_q), .sat(r_sat));
   mfr_delay #(.WIDTH(2*W+2), .DEPTH(LD)) u_dly5 (
      .clock(clock), .reset(reset), .en(adv),
      .d({s4[2*W+1], s4[2*W] | num_sat | den_sat, s4[2*W-1:0]}), .q(s5));

   // inverse ratio
   logic [W-1:0]   ir_q;
   logic           ir_sat;
   logic [3*W+1:0] s6;

   mfr_div #(.W(W), .F(F)) u_div_ir (
      .clock(clock), .en(adv), .a(ONE_V), .b(r_q), .q(ir_q), .sat(ir_sat));
   mfr_delay #(.WIDTH(3*W+2), .DEPTH(LD)) u_dly6 (
      .clock(clock), .reset(reset), .en(adv),
      .d({s5[2*W+1], s5[2*W] | r_sat, s5[2*W-1:0], r_q}), .q(s6));

   // squares for the limiter
   logic [W-1:0]   xr_q, xi_q;
   logic           xr_sat, xi_sat;
   logic [4*W+2:0] s7;

   mfr_mul #(.W(W), .F(F)) u_mul_xr (
      .clock(clock), .en(adv), .a(s6[W-1:0]), .b(s6[W-1:0]), .q(xr_q), .sat(xr_sat));
   mfr_mul #(.W(W), .F(F)) u_mul_xi (
      .clock(clock), .en(adv), .a(ir_q), .b(ir_q), .q(xi_q), .sat(xi_sat));
   mfr_delay #(.WIDTH(4*W+3), .DEPTH(LM)) u_dly7 (
      .clock(clock), .reset(reset), .en(adv),
      .d({s6[3*W+1], s6[3*W], ir_sat, s6[3*W-1:0], ir_q}), .q(s7));

   // t8: limiter numerator and denominator
   logic [W:0]   ar_c, br_c, ai_c, bi_c;
   logic         l_v_ff, l_sat_ff, l_vsat_ff;
   logic [W-1:0] l_near_ff, l_nf_ff, l_r_ff, l_ar_ff, l_br_ff, l_ai_ff, l_bi_ff;

   always_comb begin
      ar_c = add_s(s7[2*W-1:W], xr_q);
      br_c = add_s(ONE_V, xr_q);
      ai_c = add_s(s7[W-1:0], xi_q);
      bi_c = add_s(ONE_V, xi_q);
   end

   always_ff @(posedge clock) begin
      if (reset) l_v_ff <= 1'b0;
      else if (adv) l_v_ff <= s7[4*W+2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_sat_ff  <= s7[4*W+1];
         l_vsat_ff <= s7[4*W] | xr_sat | xi_sat | ar_c[W] | br_c[W] | ai_c[W] | bi_c[W];
         l_near_ff <= s7[4*W-1:3*W];
         l_nf_ff   <= s7[3*W-1:2*W];
         l_r_ff    <= s7[2*W-1:W];
         l_ar_ff   <= ar_c[W-1:0];
         l_br_ff   <= br_c[W-1:0];
         l_ai_ff   <= ai_c[W-1:0];
         l_bi_ff   <= bi_c[W-1:0];
      end
   end

   // limiter quotients
   logic [W-1:0]   vr_q, vi_q;
   logic           vr_sat, vi_sat;
   logic [3*W+2:0] s9;

   mfr_div #(.W(W), .F(F)) u_div_vr (
      .clock(clock), .en(adv), .a(l_ar_ff), .b(l_br_ff), .q(vr_q), .sat(vr_sat));
   mfr_div #(.W(W), .F(F)) u_div_vi (
      .clock(clock), .en(adv), .a(l_ai_ff), .b(l_bi_ff), .q(vi_q), .sat(vi_sat));
   mfr_delay #(.WIDTH(3*W+3), .DEPTH(LD)) u_dly9 (
      .clock(clock), .reset(reset), .en(adv),
      .d({l_v_ff, l_sat_ff, l_vsat_ff, l_near_ff, l_nf_ff, l_r_ff}), .q(s9));

   // t10: limiter select; limiter-path clamps count only with van Albada on
   logic         m_v_ff, m_sat_ff;
   logic [W-1:0] m_near_ff, m_nf_ff, m_r_ff, m_lim_ff, m_inv_ff, lim_c, inv_c;

   always_comb begin
      lim_c = mode_ff ? (vr_q[W-1] ? '0 : vr_q) : ONE_V;
      inv_c = mode_ff ? (vi_q[W-1] ? '0 : vi_q) : ONE_V;
   end

   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else if (adv) m_v_ff <= s9[3*W+2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_sat_ff  <= s9[3*W+1] | (mode_ff & (s9[3*W] | vr_sat | vi_sat));
         m_near_ff <= s9[3*W-1:2*W];
         m_nf_ff   <= s9[2*W-1:W];
         m_r_ff    <= s9[W-1:0];
         m_lim_ff  <= lim_c;
         m_inv_ff  <= inv_c;
      end
   end

   // kappa weighting
   logic [W-1:0]   t1_q, m2_q;
   logic           t1_sat, m2_sat;
   logic [3*W+1:0] s11;

   mfr_mul #(.W(W), .F(F)) u_mul_t1 (
      .clock(clock), .en(adv), .a(omk_c[W-1:0]), .b(m_lim_ff), .q(t1_q), .sat(t1_sat));
   mfr_mul #(.W(W), .F(F)) u_mul_m2 (
      .clock(clock), .en(adv), .a(opk_c[W-1:0]), .b(m_r_ff), .q(m2_q), .sat(m2_sat));
   mfr_delay #(.WIDTH(3*W+2), .DEPTH(LM)) u_dly11 (
      .clock(clock), .reset(reset), .en(adv),
      .d({m_v_ff, m_sat_ff, m_near_ff, m_nf_ff, m_inv_ff}), .q(s11));

   logic [W-1:0]   t2_q;
   logic           t2_sat;
   logic [3*W+1:0] s12;

   mfr_mul #(.W(W), .F(F)) u_mul_t2 (
      .clock(clock), .en(adv), .a(m2_q), .b(s11[W-1:0]), .q(t2_q), .sat(t2_sat));
   mfr_delay #(.WIDTH(3*W+2), .DEPTH(LM)) u_dly12 (
      .clock(clock), .reset(reset), .en(adv),
      .d({s11[3*W+1], s11[3*W] | t1_sat | m2_sat, s11[3*W-1:W], t1_q}), .q(s12));

   // t13: slope sum
   logic [W:0]   sum_c;
   logic         g_v_ff, g_sat_ff;
   logic [W-1:0] g_near_ff, g_nf_ff, g_s_ff;

   assign sum_c = add_s(s12[W-1:0], t2_q);

   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else if (adv) g_v_ff <= s12[3*W+1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_sat_ff  <= s12[3*W] | t2_sat | sum_c[W];
         g_near_ff <= s12[3*W-1:2*W];
         g_nf_ff   <= s12[2*W-1:W];
         g_s_ff    <= sum_c[W-1:0];
      end
   end

   logic [W-1:0]   qm_q;
   logic           qm_sat;
   logic [W+1:0]   s14;

   mfr_mul #(.W(W), .F(F)) u_mul_q (
      .clock(clock), .en(adv), .a(g_nf_ff), .b(g_s_ff), .q(qm_q), .sat(qm_sat));
   mfr_delay #(.WIDTH(W+2), .DEPTH(LM)) u_dly14 (
      .clock(clock), .reset(reset), .en(adv),
      .d({g_v_ff, g_sat_ff, g_near_ff}), .q(s14));

   // t15: quarter, truncated toward zero
   logic [W:0]   qe_c;
   logic         h_v_ff, h_sat_ff;
   logic [W-1:0] h_near_ff, h_q4_ff;

   assign qe_c = {qm_q[W-1], qm_q} + (qm_q[W-1] ? (W+1)'(3) : (W+1)'(0));

   always_ff @(posedge clock) begin
      if (reset) h_v_ff <= 1'b0;
      else if (adv) h_v_ff <= s14[W+1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_sat_ff  <= s14[W] | qm_sat;
         h_near_ff <= s14[W-1:0];
         h_q4_ff   <= {qe_c[W], qe_c[W:2]};
      end
   end

   // output register
   logic [W:0]   face_c;
   logic [W-1:0] face_ff;
   logic         sat_ff;

   assign face_c = add_s(h_near_ff, h_q4_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= h_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         face_ff <= face_c[W-1:0];
         sat_ff  <= h_sat_ff | face_c[W] | cfg_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_face_value = OUT_WIDTH'(signed'(face_ff));
   assign rsp_saturated  = sat_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_checker.sv =====
// Port-level checks for the face reconstruction block, bound to the top level.
`default_nettype none
module mfr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [mfr_pkg::OUT_WIDTH-1:0]      rsp_face_value,
   input wire logic                               rsp_saturated
);
   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_face_value) && $stable(rsp_saturated))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      req_stall && !(rsp_valid && rsp_stall) |=> !req_stall)
      else $error("input stall held after output moved");
endmodule

bind muscl_face_reconstruction mfr_checker u_mfr_checker (.*);
`default_nettype wire

// ===== sim/tb_muscl_face_reconstruction.sv =====
// Self-checking testbench for the MUSCL face reconstruction block with a predictor and scoreboard.
`timescale 1ns / 100ps
module tb_muscl_face_reconstruction;
   import mfr_pkg::*;

   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;
   localparam longint ONE  = 64'sd65536;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 140;

   typedef struct packed {
      logic [31:0] far_v;
      logic [31:0] near_v;
      logic [31:0] down_v;
      logic [30:0] ud;
      logic [30:0] cd;
   } cell_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_far_upwind = '0;
   logic [31:0] req_near_upwind = '0;
   logic [31:0] req_downwind = '0;
   logic [30:0] req_upwind_distance = '0;
   logic [30:0] req_central_distance = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_face_value;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_LIMITER_MODE;
   logic [CSR_DATA_WIDTH-1:0] csr_wr_data = '0;

   cell_set_type pending_cells[$];
   logic [31:0] face_exp_q[$];
   logic sat_exp_q[$];

   logic lim_van_albada = 1'b1;
   logic [17:0] kappa_reg = '0;
   logic clip;
   logic idle_on = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_reqs = 0;
   int holds_served = 0;
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int sat_beats = 0;

   muscl_face_reconstruction dut (.*);

   always #5 clock = ~clock;

   function automatic longint clampv(input longint x);
      if (x > MAXV) begin
         clip = 1'b1;
         return MAXV;
      end
      if (x < MINV) begin
         clip = 1'b1;
         return MINV;
      end
      return x;
   endfunction

   function automatic longint mul_fx(input longint a, input longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = m >> 16;
      return clampv((p < 0) ? -m : m);
   endfunction

   function automatic longint div_fx(input longint a, input longint b);
      if (b == 0) begin
         clip = 1'b1;
         return (a < 0) ? MINV : MAXV;
      end
      return clampv((a * 65536) / b);
   endfunction

   function automatic longint van_albada_fx(input longint x);
      longint xx, v;
      xx = mul_fx(x, x);
      v = div_fx(clampv(x + xx), clampv(ONE + xx));
      return (v < 0) ? 0 : v;
   endfunction

   function automatic void predict_face(input cell_set_type c);
      longint fv, nv, dv, udv, cdv, k, num, den, r, lim, inv, s, q;
      clip = 1'b0;
      fv = longint'(signed'(c.far_v));
      nv = longint'(signed'(c.near_v));
      dv = longint'(signed'(c.down_v));
      udv = longint'(c.ud);
      cdv = longint'(c.cd);
      k = longint'(signed'(kappa_reg));
      num = div_fx(clampv(clampv(dv - nv) + 1), cdv);
      den = div_fx(clampv(clampv(nv - fv) + 1), udv);
      r = div_fx(num, den);
      if (lim_van_albada) begin
         lim = van_albada_fx(r);
         inv = van_albada_fx(div_fx(ONE, r));
      end else begin
         lim = ONE;
         inv = ONE;
      end
      s = clampv(mul_fx(clampv(ONE - k), lim) + mul_fx(mul_fx(clampv(ONE + k), r), inv));
      q = mul_fx(clampv(nv - fv), s);
      face_exp_q.push_back(32'(clampv(nv + q / 4)));
      sat_exp_q.push_back(clip);
   endfunction

   // sender
   always @(posedge clock) begin
      logic nxt_valid;
      cell_set_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         if (req_valid && !req_stall) begin
            c = '{req_far_upwind, req_near_upwind, req_downwind,
                  req_upwind_distance, req_central_distance};
            predict_face(c);
            beats_in++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_cells.size() > 0) begin
               c = pending_cells.pop_front();
               req_far_upwind <= c.far_v;
               req_near_upwind <= c.near_v;
               req_downwind <= c.down_v;
               req_upwind_distance <= c.ud;
               req_central_distance <= c.cd;
               nxt_valid = 1'b1;
               send_gap = idle_on ? $urandom_range(0, 17) : 0;
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      logic [31:0] exp_face;
      logic exp_sat;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (face_exp_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat face=%h sat=%b", $time, rsp_face_value,
                        rsp_saturated);
            end else begin
               exp_face = face_exp_q.pop_front();
               exp_sat = sat_exp_q.pop_front();
               if (exp_sat) sat_beats++;
               if (rsp_face_value !== exp_face) begin
                  errors++;
                  $display("%0t: face_value expected %h actual %h", $time, exp_face,
                           rsp_face_value);
               end
               if (rsp_saturated !== exp_sat) begin
                  errors++;
                  $display("%0t: saturated expected %b actual %b", $time, exp_sat,
                           rsp_saturated);
               end
            end
            stall_left = idle_on ? $urandom_range(0, 17) : 0;
         end
         if (holds_served < hold_reqs) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [17:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      if (idx == CSR_LIMITER_MODE) lim_van_albada = data[0];
      else kappa_reg = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_cells(input logic [31:0] f, n, d, input logic [30:0] u, c);
      pending_cells.push_back('{f, n, d, u, c});
   endtask

   // sample after the edge has settled so a beat just launched is seen
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (pending_cells.size() > 0 || req_valid || face_exp_q.size() > 0) begin
         @(posedge clock);
         #1;
      end
      @(posedge clock);
   endtask

   task automatic add_random(input int count);
      logic [31:0] n;
      int sel;
      repeat (count) begin
         sel = $urandom_range(0, 9);
         n = $urandom_range(0, 32'h00100000) - 32'h00080000;
         if (sel < 6)
            add_cells(n + $urandom_range(0, 32'h20000) - 32'h10000, n,
                      n + $urandom_range(0, 32'h20000) - 32'h10000,
                      31'($urandom_range(32'h4000, 32'h40000)),
                      31'($urandom_range(32'h4000, 32'h40000)));
         else if (sel < 9)
            add_cells($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
         else
            add_cells(n, n + $urandom_range(0, 3) - 1, $urandom, 31'($urandom_range(0, 3)),
                      31'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_reg(CSR_LIMITER_MODE, 18'd1);
      write_reg(CSR_KAPPA, 18'd0);
      add_cells(32'h0, 32'h0, 32'h0, 31'h10000, 31'h10000);
      add_cells(32'h0, 32'h10000, 32'h20000, 31'h10000, 31'h10000);
      add_cells(32'h20000, 32'h10000, 32'h30000, 31'h10000, 31'h10000);
      add_cells(32'h0, 32'h10000, 32'h8000, 31'h10000, 31'h20000);
      add_cells(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h1, 31'h1);
      add_cells(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      add_cells(32'h80000000, 32'h80000000, 32'h80000000, 31'h1, 31'h7FFFFFFF);
      add_cells(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h1);
      add_cells(32'h10000, 32'h0, 32'hFFFF0000, 31'h0, 31'h10000);
      add_cells(32'h0, 32'h10000, 32'h20000, 31'h10000, 31'h0);
      add_cells(32'h0, 32'h0, 32'h5000, 31'h10000, 31'h10000);
      add_cells(32'h1, 32'h0, 32'h0, 31'h10000, 31'h10000);
      add_cells(32'h0, 32'h10000, 32'hFFFFFFFF, 31'h1, 31'h1);
      add_cells(32'hFFFFFFFF, 32'h0, 32'h0, 31'h10000, 31'h10000);
      add_cells(32'h12345678, 32'h12340000, 32'h12350000, 31'h8000, 31'h18000);
      add_cells(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 31'h55555555, 31'h2AAAAAAA);
      add_cells(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA, 31'h55555555);
      add_cells(32'h0, 32'hFFFF, 32'h0, 31'h1, 31'h1);
      add_cells(32'hFFFF0000, 32'h0, 32'h10000, 31'h10000, 31'h10000);
      add_cells(32'h0, 32'h1000000, 32'h7F000000, 31'h100, 31'h100);
      add_random(80);
      wait_idle();
      write_reg(CSR_LIMITER_MODE, 18'd0);
      write_reg(CSR_KAPPA, 18'h30000);
      add_random(100);
      wait_idle();
      write_reg(CSR_LIMITER_MODE, 18'h3FFFF);
      write_reg(CSR_KAPPA, 18'h10000);
      hold_reqs++;
      idle_on = 1'b0;
      add_random(110);
      wait_idle();
      idle_on = 1'b1;
      write_reg(CSR_KAPPA, 18'h1FFFF);
      add_random(100);
      wait_idle();
      write_reg(CSR_LIMITER_MODE, 18'h3FFFE);
      write_reg(CSR_KAPPA, 18'h20000);
      add_random(100);
      wait_idle();
      write_reg(CSR_LIMITER_MODE, 18'd1);
      write_reg(CSR_KAPPA, 18'($urandom_range(0, 32'h20000) - 32'h10000));
      add_random(140);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (face_exp_q.size() > 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, face_exp_q.size());
      end
      $display("Covered %0d beats in, %0d out, %0d saturated, over six limiter/kappa settings",
               beats_in, beats_out, sat_beats);
      if (errors == 0)
         $display("tb_muscl_face_reconstruction: PASS");
      else
         $display("tb_muscl_face_reconstruction: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout at %0t", $time);
      $display("tb_muscl_face_reconstruction: FAIL");
      $finish;
   end
endmodule

// ===== muscl_face_reconstruction.f =====
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_delay.sv
hw/rtl/mfr_mul.sv
hw/rtl/mfr_div.sv
hw/rtl/muscl_face_reconstruction.sv
hw/rtl/mfr_checker.sv
sim/tb_muscl_face_reconstruction.sv
